// ===== rtl/core/dps_pkg.sv =====
// ============================================================================
// dps_pkg
// Shared types and constants for the distance pair squasher: fixed-point
// constants, pipeline lengths, register indexes and the sideband record.
// ============================================================================
package dps_pkg;

    // Pipeline segment lengths.
    localparam int DIV_STEPS  = 25;
    localparam int DIV2_STEPS = 16;
    localparam int HORNER_N   = 10;
    localparam int EXP_LAT    = 3 * HORNER_N + 3;
    localparam int PIPE_DEPTH = 2 + DIV_STEPS + 1 + EXP_LAT + 1 + DIV2_STEPS + 1;

    // Fixed-point constants.
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
    localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
    localparam logic [29:0] LN2_Q30    = 30'd744261118;
    localparam logic [25:0] EXP_LIMIT  = 26'd33554432;
    localparam logic [15:0] SCORE_ONE  = 16'd32768;
    localparam logic [15:0] SCORE_HALF = 16'd16384;

    // floor(2^32 / n) for the Horner divisions by n.
    localparam logic [32:0] RECIP_TAB [0:10] = '{
        33'd0,
        33'd4294967296,
        33'd2147483648,
        33'd1431655765,
        33'd1073741824,
        33'd858993459,
        33'd715827882,
        33'd613566756,
        33'd536870912,
        33'd477218588,
        33'd429496729
    };

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_SIGMA = 2'd1;
    localparam logic [1:0] REG_LOW   = 2'd2;

    typedef enum logic [1:0] {
        MODE_LOGISTIC = 2'd0,
        MODE_THRESH   = 2'd1,
        MODE_GAUSS    = 2'd2,
        MODE_FLEX     = 2'd3
    } t_mode;

    // Per-transaction control record that travels beside the datapath.
    typedef struct packed {
        logic        direct;
        logic [15:0] score;
        logic        cgtf;
        logic        gauss;
        logic        a_one;
        logic        a_zero;
        logic        b_one;
        logic        b_zero;
    } t_side;

endpackage

// ===== rtl/core/dps_exp.sv =====
// ============================================================================
// dps_exp
// Pipelined exp(-u): u is unsigned Q.20, the result unsigned Q1.30. Range
// reduction by log2(e), a degree-10 Horner series and a final right shift.
// ============================================================================
module dps_exp import dps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [25:0] i_u,
    output logic [30:0] o_p
);

    logic [56:0] n_prod_v;
    logic [26:0] r_v;
    logic        r_big0;
    logic [49:0] n_prod_g;
    logic [29:0] r_g;
    logic [6:0]  r_k;
    logic        r_big1;

    // Horner stage registers, three substages per coefficient.
    logic [60:0] r_prod [0:HORNER_N-1];
    logic [29:0] r_ag   [0:HORNER_N-1];
    logic [6:0]  r_ak   [0:HORNER_N-1];
    logic        r_abig [0:HORNER_N-1];
    logic [63:0] r_m    [0:HORNER_N-1];
    logic [30:0] r_ba   [0:HORNER_N-1];
    logic [29:0] r_bg   [0:HORNER_N-1];
    logic [6:0]  r_bk   [0:HORNER_N-1];
    logic        r_bbig [0:HORNER_N-1];
    logic [30:0] r_p    [0:HORNER_N-1];
    logic [29:0] r_cg   [0:HORNER_N-1];
    logic [6:0]  r_ck   [0:HORNER_N-1];
    logic        r_cbig [0:HORNER_N-1];
    logic [30:0] r_out;

    // Scale by log2(e) so that the integer part is a power-of-two shift.
    assign n_prod_v = 57'(i_u) * 57'(LOG2E_Q30);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v    <= n_prod_v[56:30];
            r_big0 <= (i_u >= EXP_LIMIT);
        end
    end

    // The fraction goes back to the natural scale for the series.
    assign n_prod_g = 50'(r_v[19:0]) * 50'(LN2_Q30);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g    <= n_prod_g[49:20];
            r_k    <= r_v[26:20];
            r_big1 <= r_big0;
        end
    end

    // One Horner step per coefficient: p = 1 - (g*p)/n.
    for (genvar j = 0; j < HORNER_N; j++) begin : g_horner
        localparam int NSTEP = HORNER_N - j;
        logic [30:0] p_in;
        logic [29:0] g_in;
        logic [6:0]  k_in;
        logic        big_in;
        logic [31:0] q0;
        logic [35:0] qn;
        logic [35:0] rr;
        logic [30:0] q;

        if (j == 0) begin : g_first
            assign p_in   = ONE_Q30;
            assign g_in   = r_g;
            assign k_in   = r_k;
            assign big_in = r_big1;
        end else begin : g_next
            assign p_in   = r_p[j-1];
            assign g_in   = r_cg[j-1];
            assign k_in   = r_ck[j-1];
            assign big_in = r_cbig[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_prod[j] <= 61'(g_in) * 61'(p_in);
                r_ag[j]   <= g_in;
                r_ak[j]   <= k_in;
                r_abig[j] <= big_in;
            end
        end

        // Division by a constant through its reciprocal, corrected below.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[j]    <= 64'(r_prod[j][60:30]) * 64'(RECIP_TAB[NSTEP]);
                r_ba[j]   <= r_prod[j][60:30];
                r_bg[j]   <= r_ag[j];
                r_bk[j]   <= r_ak[j];
                r_bbig[j] <= r_abig[j];
            end
        end

        assign q0 = r_m[j][63:32];
        assign qn = 36'(q0) * 36'(NSTEP);
        assign rr = 36'(r_ba[j]) - qn;
        assign q  = q0[30:0] + 31'(rr >= 36'(NSTEP));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[j]    <= ONE_Q30 - q;
                r_cg[j]   <= r_bg[j];
                r_ck[j]   <= r_bk[j];
                r_cbig[j] <= r_bbig[j];
            end
        end
    end

    // Apply the power-of-two part; large arguments underflow to zero.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_cbig[HORNER_N-1] || (r_ck[HORNER_N-1] >= 7'd31)) begin
                r_out <= '0;
            end else begin
                r_out <= r_p[HORNER_N-1] >> r_ck[HORNER_N-1][4:0];
            end
        end
    end

    assign o_p = r_out;

endmodule

// ===== rtl/core/distance_pair_squasher.sv =====
// ============================================================================
// distance_pair_squasher
// Maps a pair of Q8.8 distances to a Q1.15 score through a logistic,
// threshold or gaussian squasher chosen by the mode register.
// ============================================================================
//  Channel   Handshake              Payload
//  input     i_valid / o_stall      i_closer, i_farther
//  output    o_valid / i_stall      o_score
//  config    psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// One transaction enters per cycle unless the output is stalled; each result
// passes through the 25-step quotient pipeline, the 33-stage exp pipeline and
// the 16-step score division. Reset clears the valid bits and loads the
// register defaults. A stall at the output freezes every stage together, so
// no transaction is lost or repeated.
// ============================================================================
module distance_pair_squasher import dps_pkg::*; #(
    parameter int DIST_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_closer,
    input  logic [15:0] i_farther,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_score,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DW = (DIST_WIDTH < 16) ? DIST_WIDTH : 16;

    t_mode       r_mode;
    logic [15:0] r_sigma;
    logic [15:0] r_low;
    logic        cfg_wr;
    logic        en;
    logic [PIPE_DEPTH-1:0] r_vld;

    // Stage 0 and 1 registers.
    logic [DW-1:0] r0_c, r0_f, r0_sg;
    t_mode         r0_mode;
    logic [15:0]   r0_low;
    logic [DW-1:0] r1_xa, r1_xb, r1_s;
    t_side         r1_side;

    // Prep logic.
    logic [DW-1:0] diff, s_sel, xa;
    logic          cgtf, gauss, szero;
    logic [DW+4:0] s32, s8, lim_a;
    logic          a_ge, b_ge;
    logic [DW:0]   f_plus;
    t_side         n_side;

    // Quotient pipeline.
    logic [DW-1:0]        rd_rem_a [0:DIV_STEPS-1];
    logic [DW-1:0]        rd_rem_b [0:DIV_STEPS-1];
    logic [DIV_STEPS-1:0] rd_qf_a  [0:DIV_STEPS-1];
    logic [DIV_STEPS-1:0] rd_qf_b  [0:DIV_STEPS-1];
    logic [DW-1:0]        rd_s     [0:DIV_STEPS-1];
    t_side                rd_side  [0:DIV_STEPS-1];

    // Square stage and exp.
    logic [DIV_STEPS-1:0] qa, qb;
    logic [45:0]          sq_a, sq_b;
    logic [25:0]          r_sq_ua, r_sq_ub;
    t_side                r_sq_side;
    logic [30:0]          ea, eb;
    t_side                rx_side [0:EXP_LAT-1];

    // Combine stage and score division.
    logic [30:0] va, vb;
    logic [31:0] gnum, den;
    logic [15:0] gscore;
    t_side       n_f_side;
    logic [31:0] r_f_rem, r_f_den;
    logic [15:0] r_f_qf;
    t_side       r_f_side;
    logic [31:0] r2_rem  [0:DIV2_STEPS-1];
    logic [15:0] r2_qf   [0:DIV2_STEPS-1];
    logic [31:0] r2_den  [0:DIV2_STEPS-1];
    t_side       r2_side [0:DIV2_STEPS-1];
    logic [15:0] qs, lscore;
    logic [15:0] r_out_score;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_LOGISTIC;
            r_sigma <= 16'd256;
            r_low   <= 16'd3277;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_MODE:  r_mode  <= t_mode'(pwdata[1:0]);
                REG_SIGMA: r_sigma <= pwdata[15:0];
                REG_LOW:   r_low   <= pwdata[15:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MODE:  prdata = {30'd0, r_mode};
            REG_SIGMA: prdata = {16'd0, r_sigma};
            REG_LOW:   prdata = {16'd0, r_low};
            default:   prdata = '0;
        endcase
    end

    // Global advance: everything moves unless a finished result is stalled.
    assign en      = !(r_vld[PIPE_DEPTH-1] && i_stall);
    assign o_stall = r_vld[PIPE_DEPTH-1] && i_stall;
    assign o_valid = r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_valid};
        end
    end

    // Stage 0: capture the transaction and the registers it uses.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_c    <= i_closer[DW-1:0];
            r0_f    <= i_farther[DW-1:0];
            r0_sg   <= r_sigma[DW-1:0];
            r0_mode <= r_mode;
            r0_low  <= r_low;
        end
    end

    // Stage 1: pick operands, range checks and the scores needing no math.
    assign cgtf   = r0_c > r0_f;
    assign diff   = cgtf ? (r0_c - r0_f) : (r0_f - r0_c);
    assign gauss  = (r0_mode == MODE_GAUSS) || (r0_mode == MODE_FLEX);
    assign s_sel  = (r0_mode == MODE_FLEX) ? diff : r0_sg;
    assign xa     = (r0_mode == MODE_LOGISTIC) ? diff : r0_c;
    assign szero  = (s_sel == '0);
    assign s32    = {s_sel, 5'd0};
    assign s8     = {2'd0, s_sel, 3'd0};
    assign lim_a  = gauss ? s8 : s32;
    assign a_ge   = {5'd0, xa} >= lim_a;
    assign b_ge   = {5'd0, r0_f} >= s8;
    assign f_plus = {1'b0, r0_f} + {1'b0, r0_sg};

    always_comb begin
        n_side        = '0;
        n_side.cgtf   = cgtf;
        n_side.gauss  = gauss;
        n_side.a_one  = gauss && szero && (xa == '0);
        n_side.a_zero = gauss ? (szero ? (xa != '0) : a_ge) : a_ge;
        n_side.b_one  = gauss && szero && (r0_f == '0);
        n_side.b_zero = gauss ? (szero ? (r0_f != '0) : b_ge) : 1'b1;
        if (r0_mode == MODE_THRESH) begin
            n_side.direct = 1'b1;
            if ({1'b0, r0_c} < f_plus) begin
                n_side.score = SCORE_ONE;
            end else begin
                n_side.score = (r0_low > SCORE_ONE) ? SCORE_ONE : r0_low;
            end
        end else if ((r0_mode == MODE_LOGISTIC) && (r0_sg == '0)) begin
            n_side.direct = 1'b1;
            if (r0_c < r0_f) begin
                n_side.score = SCORE_ONE;
            end else if (cgtf) begin
                n_side.score = '0;
            end else begin
                n_side.score = SCORE_HALF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_xa   <= xa;
            r1_xb   <= r0_f;
            r1_s    <= s_sel;
            r1_side <= n_side;
        end
    end

    // Restoring division (x << 20) / s, one quotient bit per stage, two lanes.
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        logic [DW-1:0]        rem_a_in, rem_b_in, s_in;
        logic [DIV_STEPS-1:0] qf_a_in, qf_b_in;
        t_side                side_in;
        logic [DW:0]          t_a, t_b;
        logic                 ge_a, ge_b;

        if (j == 0) begin : g_first
            assign rem_a_in = r1_xa >> 5;
            assign rem_b_in = r1_xb >> 5;
            assign qf_a_in  = {r1_xa[4:0], 20'd0};
            assign qf_b_in  = {r1_xb[4:0], 20'd0};
            assign s_in     = r1_s;
            assign side_in  = r1_side;
        end else begin : g_next
            assign rem_a_in = rd_rem_a[j-1];
            assign rem_b_in = rd_rem_b[j-1];
            assign qf_a_in  = rd_qf_a[j-1];
            assign qf_b_in  = rd_qf_b[j-1];
            assign s_in     = rd_s[j-1];
            assign side_in  = rd_side[j-1];
        end

        assign t_a  = {rem_a_in, qf_a_in[DIV_STEPS-1]};
        assign t_b  = {rem_b_in, qf_b_in[DIV_STEPS-1]};
        assign ge_a = t_a >= {1'b0, s_in};
        assign ge_b = t_b >= {1'b0, s_in};

        always_ff @(posedge i_clk) begin
            if (en) begin
                rd_rem_a[j] <= ge_a ? DW'(t_a - {1'b0, s_in}) : t_a[DW-1:0];
                rd_rem_b[j] <= ge_b ? DW'(t_b - {1'b0, s_in}) : t_b[DW-1:0];
                rd_qf_a[j]  <= {qf_a_in[DIV_STEPS-2:0], ge_a};
                rd_qf_b[j]  <= {qf_b_in[DIV_STEPS-2:0], ge_b};
                rd_s[j]     <= s_in;
                rd_side[j]  <= side_in;
            end
        end
    end

    // Gaussian modes square the ratio; logistic uses the quotient directly.
    assign qa   = rd_qf_a[DIV_STEPS-1];
    assign qb   = rd_qf_b[DIV_STEPS-1];
    assign sq_a = 46'(qa[22:0]) * 46'(qa[22:0]);
    assign sq_b = 46'(qb[22:0]) * 46'(qb[22:0]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_ua   <= rd_side[DIV_STEPS-1].gauss ? sq_a[45:20] : {1'b0, qa};
            r_sq_ub   <= sq_b[45:20];
            r_sq_side <= rd_side[DIV_STEPS-1];
        end
    end

    dps_exp u_exp_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_u   (r_sq_ua),
        .o_p   (ea)
    );

    dps_exp u_exp_b (
        .i_clk (i_clk),
        .i_en  (en),
        .i_u   (r_sq_ub),
        .o_p   (eb)
    );

    // Sideband follows the exp pipeline.
    always_ff @(posedge i_clk) begin
        if (en) begin
            rx_side[0] <= r_sq_side;
            for (int i = 1; i < EXP_LAT; i++) begin
                rx_side[i] <= rx_side[i-1];
            end
        end
    end

    // Combine: forced lane values, gaussian mix, setup of the score division.
    assign va = rx_side[EXP_LAT-1].a_one ? ONE_Q30 :
                (rx_side[EXP_LAT-1].a_zero ? 31'd0 : ea);
    assign vb = rx_side[EXP_LAT-1].b_one ? ONE_Q30 :
                (rx_side[EXP_LAT-1].b_zero ? 31'd0 : eb);
    assign gnum   = 32'(ONE_Q30) + 32'(va) - 32'(vb) + 32'd32768;
    assign gscore = (gnum[31:16] > SCORE_ONE) ? SCORE_ONE : gnum[31:16];
    assign den    = 32'(ONE_Q30) + 32'(va);

    // Gaussian scores are final here and ride the sideband from now on.
    always_comb begin
        n_f_side = rx_side[EXP_LAT-1];
        if (rx_side[EXP_LAT-1].gauss) begin
            n_f_side.direct = 1'b1;
            n_f_side.score  = gscore;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_side <= n_f_side;
            r_f_rem  <= 32'h2000_0000 + (den >> 17);
            r_f_qf   <= den[16:1];
            r_f_den  <= den;
        end
    end

    // Restoring division (2^45 + den/2) / den, one bit per stage.
    for (genvar j = 0; j < DIV2_STEPS; j++) begin : g_div2
        logic [31:0]           rem_in, den_in;
        logic [DIV2_STEPS-1:0] qf_in;
        t_side                 side_in;
        logic [32:0]           t;
        logic                  ge;

        if (j == 0) begin : g_first
            assign rem_in  = r_f_rem;
            assign den_in  = r_f_den;
            assign qf_in   = r_f_qf;
            assign side_in = r_f_side;
        end else begin : g_next
            assign rem_in  = r2_rem[j-1];
            assign den_in  = r2_den[j-1];
            assign qf_in   = r2_qf[j-1];
            assign side_in = r2_side[j-1];
        end

        assign t  = {rem_in, qf_in[DIV2_STEPS-1]};
        assign ge = t >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (en) begin
                r2_rem[j]  <= ge ? 32'(t - {1'b0, den_in}) : t[31:0];
                r2_qf[j]   <= {qf_in[DIV2_STEPS-2:0], ge};
                r2_den[j]  <= den_in;
                r2_side[j] <= side_in;
            end
        end
    end

    // Output stage: direct scores pass through; the logistic score is folded by the sign of the difference.
    assign qs     = r2_qf[DIV2_STEPS-1];
    assign lscore = (qs > SCORE_ONE) ? SCORE_ONE : qs;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r2_side[DIV2_STEPS-1].direct) begin
                r_out_score <= r2_side[DIV2_STEPS-1].score;
            end else if (r2_side[DIV2_STEPS-1].cgtf) begin
                r_out_score <= SCORE_ONE - lscore;
            end else begin
                r_out_score <= lscore;
            end
        end
    end

    assign o_score = r_out_score;

    // A delivered score never exceeds 1.0.
    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_score <= SCORE_ONE))
        else $error("score above 1.0");

    // A stalled result freezes the whole pipeline.
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(r_vld))
        else $error("pipeline moved under stall");

    // An accepted transaction occupies the first stage in the next cycle.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted transaction lost at entry");

endmodule
